// ===== hw/rtl/cnc_response_line_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Response line parser assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CNC_RESPONSE_LINE_PARSER_DEFINES_SVH
`define CNC_RESPONSE_LINE_PARSER_DEFINES_SVH

// same-cycle implication
`define CRLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crlp check failed");

// next-cycle implication
`define CRLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crlp check failed");

`endif

// ===== hw/rtl/crlp_pkg.sv =====
// ---------------------------------------------------------------------------
// Response line parser package
// Beat types, result kinds and the fixed prefix texts.
// ---------------------------------------------------------------------------
package crlp_pkg;

  // result kind
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_ALARM = 2'd3
  } kind_t;

  // input beat: one character of a line
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_beat_t;

  // result beat
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] code;
  } out_beat_t;

  // candidate bit positions
  localparam int unsigned CAND_OK    = 0;
  localparam int unsigned CAND_ERROR = 1;
  localparam int unsigned CAND_ALARM = 2;

  localparam logic [2:0]  CAND_ALL   = 3'b111;
  localparam logic [2:0]  OK_LEN     = 3'd2;
  localparam logic [2:0]  PREFIX_LEN = 3'd6;
  localparam logic [2:0]  POS_MAX    = 3'd7;
  localparam logic [35:0] MAG_LIMIT  = 36'h0_8000_0000;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // "ok"
  function automatic logic [7:0] ok_char(input logic pos);
    return pos ? 8'h6b : 8'h6f;
  endfunction

  // "error:"
  function automatic logic [7:0] error_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h65;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h6f;
      3'd4:    c = 8'h72;
      default: c = 8'h3a;
    endcase
    return c;
  endfunction

  // "ALARM:"
  function automatic logic [7:0] alarm_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h4c;
      3'd2:    c = 8'h41;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4d;
      default: c = 8'h3a;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/crlp_stream_if.sv =====
// ---------------------------------------------------------------------------
// Response line parser stream channel
// Valid/ready channel carrying one payload beat.
// ---------------------------------------------------------------------------
interface crlp_stream_if #(
  parameter type payload_t = crlp_pkg::in_beat_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cnc_response_line_parser.sv =====
// ---------------------------------------------------------------------------
// CNC response line parser
// Classifies a response line as ok, error:<n> or ALARM:<n>, one char a beat.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per beat (char_byte) with last_char set on
//   the final character of the line. Empty lines are never sent.
//   out_ch carries one result per line (kind, code), produced from the
//   beat with last_char set; other characters give no result.
//   Each character is taken on its beat: the per-line state (prefix match,
//   sign, digit flags and the times-ten accumulator) updates on the beat.
//   The result is registered and appears in the cycle after the last character.
//   Throughput is one character per cycle. Characters that are not last
//   are accepted even while a result waits on out_ch; a last character
//   waits only while the result register is full and the sink is stalled.
//   Synchronous reset clears the line state and drops any pending result.
//   After each line the state returns to its reset value.
// ---------------------------------------------------------------------------
module cnc_response_line_parser (
  input  logic          clk,
  input  logic          rst_n,
  crlp_stream_if.sink   in_ch,
  crlp_stream_if.source out_ch
);

  // line state
  logic [2:0]  pos_r,  pos_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic        neg_r,  neg_nxt;
  logic        seen_r, seen_nxt;
  logic        bad_r,  bad_nxt;
  logic        ovf_r,  ovf_nxt;
  logic [31:0] mag_r,  mag_nxt;

  // result register
  logic                 out_valid_r;
  crlp_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic        accept;
  logic [7:0]  c;
  logic        is_digit;
  logic        in_number;
  logic [35:0] prod;

  assign c         = in_ch.data.char_byte;
  assign in_ch.ready = !in_ch.data.last_char || !out_valid_r || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_digit  = (c >= crlp_pkg::CHAR_ZERO) && (c <= crlp_pkg::CHAR_NINE);
  assign in_number = pos_r >= crlp_pkg::PREFIX_LEN;

  // magnitude * 10 + digit
  assign prod = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {32'd0, c[3:0]};

  // per-character update
  always_comb begin
    pos_nxt  = (pos_r == crlp_pkg::POS_MAX) ? pos_r : pos_r + 3'd1;
    cand_nxt = cand_r;
    neg_nxt  = neg_r;
    seen_nxt = seen_r;
    bad_nxt  = bad_r;
    ovf_nxt  = ovf_r;
    mag_nxt  = mag_r;

    // "ok" only survives the first two characters
    if (pos_r >= crlp_pkg::OK_LEN || c != crlp_pkg::ok_char(pos_r[0])) begin
      cand_nxt[crlp_pkg::CAND_OK] = 1'b0;
    end

    if (!in_number) begin
      if (c != crlp_pkg::error_char(pos_r)) cand_nxt[crlp_pkg::CAND_ERROR] = 1'b0;
      if (c != crlp_pkg::alarm_char(pos_r)) cand_nxt[crlp_pkg::CAND_ALARM] = 1'b0;
    end else if (pos_r == crlp_pkg::PREFIX_LEN && c == crlp_pkg::CHAR_MINUS) begin
      neg_nxt = 1'b1;
    end else if (is_digit) begin
      seen_nxt = 1'b1;
      if (!ovf_r) begin
        if (prod > crlp_pkg::MAG_LIMIT) ovf_nxt = 1'b1;
        else mag_nxt = prod[31:0];
      end
    end else begin
      bad_nxt = 1'b1;
    end
  end

  // line classification on the last character
  always_comb begin
    out_data_nxt.kind = crlp_pkg::KIND_NONE;
    out_data_nxt.code = '0;
    if (pos_r == 3'd1 && cand_nxt[crlp_pkg::CAND_OK]) begin
      out_data_nxt.kind = crlp_pkg::KIND_OK;
    end else if ((cand_nxt[crlp_pkg::CAND_ERROR] || cand_nxt[crlp_pkg::CAND_ALARM]) &&
                 in_number && seen_nxt && !bad_nxt && !ovf_nxt &&
                 (neg_nxt || !mag_nxt[31])) begin
      out_data_nxt.kind = cand_nxt[crlp_pkg::CAND_ERROR] ? crlp_pkg::KIND_ERROR
                                                         : crlp_pkg::KIND_ALARM;
      out_data_nxt.code = neg_nxt ? 32'(32'd0 - mag_nxt) : mag_nxt;
    end
  end

  // line state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cand_r      <= crlp_pkg::CAND_ALL;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      bad_r       <= 1'b0;
      ovf_r       <= 1'b0;
      mag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && in_ch.data.last_char) begin
        pos_r  <= '0;
        cand_r <= crlp_pkg::CAND_ALL;
        neg_r  <= 1'b0;
        seen_r <= 1'b0;
        bad_r  <= 1'b0;
        ovf_r  <= 1'b0;
        mag_r  <= '0;
      end else if (accept) begin
        pos_r  <= pos_nxt;
        cand_r <= cand_nxt;
        neg_r  <= neg_nxt;
        seen_r <= seen_nxt;
        bad_r  <= bad_nxt;
        ovf_r  <= ovf_nxt;
        mag_r  <= mag_nxt;
      end
      if (accept && in_ch.data.last_char) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && in_ch.data.last_char) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== hw/rtl/crlp_checker.sv =====
// ---------------------------------------------------------------------------
// Response line parser checker
// Port-level checks on result timing and payload, bound to the top level.
// ---------------------------------------------------------------------------
`include "cnc_response_line_parser_defines.svh"

module crlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input crlp_pkg::out_beat_t out_data
);

  logic in_last_beat;
  logic out_stall;

  assign in_last_beat = in_valid && in_ready && in_last;
  assign out_stall    = out_valid && !out_ready;

  // a stalled result holds
  `CRLP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data))

  // the last character of a line gives a result next cycle
  `CRLP_ASSERT_NEXT(a_last_gives_result, in_last_beat, out_valid)

  // a fresh result comes only from a last character
  `CRLP_ASSERT_NOW(a_result_from_last,
    out_valid && !($past(out_valid) && !$past(out_ready)),
    $past(in_last_beat))

  // no code without an error or alarm line
  `CRLP_ASSERT_NOW(a_code_zero,
    out_valid && (out_data.kind == crlp_pkg::KIND_NONE ||
                  out_data.kind == crlp_pkg::KIND_OK),
    out_data.code == 32'sd0)

endmodule

bind cnc_response_line_parser crlp_checker u_crlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.data.last_char),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Response line parser testbench
// Streams response lines one character per beat through the parser, with
// random sender gaps and receiver stalls. A line-level model predicts the kind
// and code of every line, and each result beat is checked against it in order.
// ---------------------------------------------------------------------------
module testbench;
  import crlp_pkg::*;

  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned TOTAL_CHARS    = 1220;

  // expected kind and code per line, built one character at a time
  class response_tracker;
    localparam string OK_TEXT    = "ok";
    localparam string ERROR_TEXT = "error:";
    localparam string ALARM_TEXT = "ALARM:";

    logic [2:0]  char_pos;
    logic [2:0]  prefix_live;
    bit          negative;
    bit          any_digit;
    bit          bad_char;
    logic [31:0] magnitude;
    bit          too_big;
    out_beat_t   expected_responses[$];
    int unsigned fail_count;
    int unsigned report_count;

    function new();
      clear_line();
      fail_count   = 0;
      report_count = 0;
    endfunction

    function void clear_line();
      char_pos    = '0;
      prefix_live = CAND_ALL;
      negative    = 1'b0;
      any_digit   = 1'b0;
      bad_char    = 1'b0;
      magnitude   = '0;
      too_big     = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (report_count < 10) begin
        report_count++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
      end
    endfunction

    // accepted character beat
    function void note_char(in_beat_t beat);
      logic [2:0]  pos;
      logic [35:0] grown;
      kind_t       kind;
      logic [31:0] code;
      out_beat_t   expected;
      pos = char_pos;
      // prefix match
      if (pos < OK_LEN) begin
        if (beat.char_byte != OK_TEXT[pos]) prefix_live[CAND_OK] = 1'b0;
      end else begin
        prefix_live[CAND_OK] = 1'b0;
      end
      if (pos < PREFIX_LEN) begin
        if (beat.char_byte != ERROR_TEXT[pos]) prefix_live[CAND_ERROR] = 1'b0;
        if (beat.char_byte != ALARM_TEXT[pos]) prefix_live[CAND_ALARM] = 1'b0;
      end else if (pos == PREFIX_LEN && beat.char_byte == CHAR_MINUS) begin
        negative = 1'b1;
      end else if (beat.char_byte >= CHAR_ZERO && beat.char_byte <= CHAR_NINE) begin
        // times-ten accumulate, frozen once past the limit
        any_digit = 1'b1;
        if (!too_big) begin
          grown = 36'(magnitude) * 36'd10 + 36'(beat.char_byte - CHAR_ZERO);
          if (grown > MAG_LIMIT) too_big = 1'b1;
          else magnitude = grown[31:0];
        end
      end else begin
        bad_char = 1'b1;
      end
      if (char_pos != POS_MAX) char_pos++;
      if (!beat.last_char) return;

      // classify the finished line
      kind = KIND_NONE;
      code = '0;
      if (pos == OK_LEN - 1 && prefix_live[CAND_OK]) begin
        kind = KIND_OK;
      end else if ((prefix_live[CAND_ERROR] || prefix_live[CAND_ALARM]) &&
                   pos >= PREFIX_LEN && any_digit && !bad_char && !too_big &&
                   (negative || magnitude < MAG_LIMIT)) begin
        kind = prefix_live[CAND_ERROR] ? KIND_ERROR : KIND_ALARM;
        code = negative ? 32'(-magnitude) : magnitude;
      end
      expected.kind = kind;
      expected.code = code;
      expected_responses.push_back(expected);
      clear_line();
    endfunction

    // accepted result beat
    function void check_result(out_beat_t got);
      out_beat_t expected;
      if (expected_responses.size() == 0) begin
        note_failure($sformatf("unexpected result kind=%0d code=%0d",
                               got.kind, got.code));
        return;
      end
      expected = expected_responses.pop_front();
      if (got.kind !== expected.kind || got.code !== expected.code) begin
        note_failure($sformatf("kind exp=%0d act=%0d, code exp=%0d act=%0d",
                               expected.kind, got.kind, expected.code, got.code));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  crlp_stream_if #(.payload_t(in_beat_t))  in_ch ();
  crlp_stream_if #(.payload_t(out_beat_t)) out_ch ();

  cnc_response_line_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  response_tracker board;
  logic [7:0]      line_chars[$];
  int unsigned     burst_left;
  int unsigned     chars_sent;
  int unsigned     stall_cycles;
  int unsigned     rx_hold_left;
  int unsigned     rx_window;
  bit              rx_hold_req;
  logic [31:0]     rx_pattern;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) board.note_char(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: rotating ready pattern, renewed every window, plus long hold-off
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_window == 0) begin
        rx_window = 40;
        case ($urandom_range(0, 3))
          0:       rx_pattern = '1;
          1:       rx_pattern = $urandom;
          2:       rx_pattern = $urandom | $urandom;
          default: rx_pattern = $urandom & $urandom;
        endcase
      end
      rx_window--;
      out_ch.ready <= rx_pattern[0];
      rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
    end
  end

  // one character beat, with sender bursts and gaps
  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{char_byte: c, last_char: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
  endtask

  // sender idle until every expected result is in
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endfunction

  function automatic void push_decimal(longint unsigned value);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(CHAR_ZERO + value % 10));
      value /= 10;
    end while (value != 0);
    foreach (digits[i]) line_chars.push_back(digits[i]);
  endfunction

  // well-formed error or alarm line, biased toward the range limits
  function automatic void build_code_line();
    longint unsigned mag;
    line_chars.delete();
    push_text($urandom_range(0, 1) ? "error:" : "ALARM:");
    if ($urandom_range(0, 4) < 2) line_chars.push_back(CHAR_MINUS);
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) line_chars.push_back(CHAR_ZERO);
    case ($urandom_range(0, 9))
      0:       mag = 0;
      1:       mag = $urandom_range(1, 9);
      2:       mag = $urandom_range(10, 999);
      3:       mag = $urandom;
      4:       mag = 64'd2147483647;
      5:       mag = 64'd2147483648;
      6:       mag = 64'd2147483649;
      7:       mag = {$urandom, $urandom};
      8:       mag = 64'd2147483640 + $urandom_range(0, 15);
      default: mag = $urandom_range(0, 65535);
    endcase
    push_decimal(mag);
  endfunction

  // one random corruption of the current line
  function automatic void break_line();
    int unsigned at;
    int unsigned ins;
    at  = $urandom_range(0, line_chars.size() - 1);
    ins = $urandom_range(0, line_chars.size());
    case ($urandom_range(0, 5))
      0:       line_chars[at] = 8'($urandom_range(0, 255));
      1:       line_chars.insert((line_chars.size() > 6) ? 6 : line_chars.size(), "+");
      2:       line_chars.insert(ins, " ");
      3:       line_chars.insert(ins, CHAR_MINUS);
      4:       while (line_chars.size() > at + 1) void'(line_chars.pop_back());
      default: line_chars[at] = line_chars[at] ^ 8'h20;
    endcase
  endfunction

  function automatic void build_random_line();
    int unsigned r;
    r = $urandom_range(0, 99);
    line_chars.delete();
    if (r < 40) begin
      build_code_line();
    end else if (r < 55) begin
      push_text("ok");
    end else if (r < 70) begin
      build_code_line();
      break_line();
    end else if (r < 80) begin
      push_text("ok");
      break_line();
    end else if (r < 90) begin
      repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      // prefix with no digits, maybe a lone minus
      push_text($urandom_range(0, 1) ? "error:" : "ALARM:");
      if ($urandom_range(0, 1)) line_chars.push_back(CHAR_MINUS);
    end
  endfunction

  task automatic send_text(string s);
    line_chars.delete();
    push_text(s);
    send_line();
  endtask

  // main sequence
  initial begin
    bit hold_done;
    bit paused;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    burst_left   = 0;
    chars_sent   = 0;
    rx_hold_req  = 1'b0;
    rx_hold_left = 0;
    rx_window    = 0;
    rx_pattern   = '1;
    hold_done    = 1'b0;
    paused       = 1'b0;
    board        = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed lines
    send_text("ok");
    send_text("Ok");
    send_text("error:-");
    send_text("ALARM:9");
    line_chars = '{8'hff};
    send_line();
    line_chars = '{8'h00};
    send_line();
    send_text("k");
    drain_results();

    // random lines, with one long receiver hold-off and one full drain
    while (chars_sent < TOTAL_CHARS) begin
      if (!hold_done && chars_sent > 450) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
      end
      if (!paused && chars_sent > 850) begin
        paused = 1'b1;
        drain_results();
      end
      build_random_line();
      send_line();
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (board.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== cnc_response_line_parser.f =====
+incdir+hw/rtl
hw/rtl/crlp_pkg.sv
hw/rtl/crlp_stream_if.sv
hw/rtl/cnc_response_line_parser.sv
hw/rtl/crlp_checker.sv
tb/testbench.sv
